FILE: sv/rpn_character_calculator_top_macros.svh
// Assertion macros shared by the calculator RTL.
`ifndef RPN_CHARACTER_CALCULATOR_TOP_MACROS_SVH
`define RPN_CHARACTER_CALCULATOR_TOP_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define RPN_ASSERT_ALWAYS(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define RPN_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RPN_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/rpn_pkg.sv
`timescale 1ns / 1ps

package rpn_pkg;

   typedef logic [2:0] status_type;

   localparam status_type STATUS_OK       = 3'd0;
   localparam status_type STATUS_CLEARED  = 3'd1;
   localparam status_type STATUS_EMPTY    = 3'd2;
   localparam status_type STATUS_FULL     = 3'd3;
   localparam status_type STATUS_DIV_ZERO = 3'd4;
   localparam status_type STATUS_RANGE    = 3'd5;

   localparam logic [7:0] CH_ENTER  = 8'h45;
   localparam logic [7:0] CH_CLEAR  = 8'h43;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_TIMES  = 8'h2A;
   localparam logic [7:0] CH_DIVIDE = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam int DIV_STEPS = 32;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_OPER,
      S_DIV,
      S_OUT
   } state_type;

endpackage

FILE: sv/rpn_character_calculator_top.sv
`timescale 1ns / 1ps
// Reverse Polish calculator that takes one character per req transaction.
// 'E' pushes a zero entry, a digit extends the top entry in decimal, the
// operators + - * / combine the top two entries, any other character
// combines them into zero, and 'C' empties the stack for the rest of the
// expression. A character with req_last set closes the expression: one rsp
// transaction then carries the top entry and a status code, with a zero
// value whenever the status is not OK. The stack lives in a synchronous
// memory with the top entry held in a register, so an operator needs one
// memory read of the entry below it. A character is taken only in the idle
// state, so the next one waits until the last is fully handled. A division
// by a nonzero divisor runs the restoring divider, which retires one
// quotient bit per cycle. A closing character also loads the response
// register, waiting while rsp_stall holds an earlier response there.
// While rsp_stall is high the held response stays put and further characters
// are still taken until another response has to be loaded.
// Reset empties the stack, clears the error and clear flags and drops any
// pending response. The memory itself is not cleared.

module rpn_character_calculator_top #(
   parameter int STACK_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_symbol,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [2:0]         rsp_status
);

   `include "rpn_character_calculator_top_macros.svh"

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int DCW = $clog2(rpn_pkg::DIV_STEPS);

   logic [31:0] stack_mem [STACK_DEPTH];

   rpn_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic signed [31:0]  top_ff, top_in;
   logic                cleared_ff, cleared_in;
   rpn_pkg::status_type err_ff, err_in;
   logic [7:0]          sym_ff, sym_in;
   logic                last_ff, last_in;
   logic [31:0]         rd_ff;
   logic [31:0]         div_rem_ff, div_rem_in;
   logic [31:0]         div_quot_ff, div_quot_in;
   logic [31:0]         div_den_ff, div_den_in;
   logic                div_neg_ff, div_neg_in;
   logic [DCW-1:0]      div_cnt_ff, div_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_value_ff, rsp_value_in;
   rpn_pkg::status_type rsp_status_ff, rsp_status_in;

   logic          mem_we;
   logic          mem_re;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;
   logic [CW-1:0] cnt_m1;
   logic [AW-1:0] cnt_m2;
   logic          req_take;
   logic          active;
   logic          is_digit;
   logic          item_done;
   logic          out_load;
   logic [3:0]    digit;
   logic signed [35:0] cur_ext;
   logic signed [35:0] cur_x10;
   logic signed [35:0] digit_val;
   logic          digit_ovf;
   logic [31:0]   a_mag;
   logic [31:0]   b_mag;
   logic [32:0]   div_shift;
   logic          div_bit;
   logic [31:0]   div_q_next;
   logic [31:0]   div_result;

   assign req_stall  = (state_ff != rpn_pkg::S_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   assign cnt_m1    = count_ff - CW'(1);
   assign cnt_m2    = AW'(count_ff - CW'(2));
   assign active    = !cleared_ff && (err_ff == rpn_pkg::STATUS_OK);
   assign is_digit  = (sym_ff >= rpn_pkg::CH_ZERO) && (sym_ff <= rpn_pkg::CH_NINE);
   assign digit     = 4'(sym_ff - rpn_pkg::CH_ZERO);
   assign cur_ext   = 36'(top_ff);
   assign cur_x10   = (cur_ext <<< 3) + (cur_ext <<< 1);
   assign digit_val = top_ff[31] ? (cur_x10 - $signed({32'd0, digit}))
                                 : (cur_x10 + $signed({32'd0, digit}));
   assign digit_ovf = (digit_val[35:31] != 5'b00000) && (digit_val[35:31] != 5'b11111);
   assign out_load  = !rsp_valid_ff || !rsp_stall;

   assign a_mag = top_ff[31] ? (~top_ff + 32'd1) : top_ff;
   assign b_mag = rd_ff[31] ? (~rd_ff + 32'd1) : rd_ff;

   assign div_shift  = {div_rem_ff, div_quot_ff[31]};
   assign div_bit    = (div_shift >= {1'b0, div_den_ff});
   assign div_q_next = {div_quot_ff[30:0], div_bit};
   assign div_result = div_neg_ff ? (~div_q_next + 32'd1) : div_q_next;

   always_comb begin
      item_done = 1'b0;
      case (state_ff)
         rpn_pkg::S_EXEC: begin
            item_done = !active || (sym_ff == rpn_pkg::CH_ENTER) || is_digit ||
                        (sym_ff == rpn_pkg::CH_CLEAR) || (count_ff < CW'(2));
         end
         rpn_pkg::S_OPER: begin
            item_done = (sym_ff != rpn_pkg::CH_DIVIDE) || (top_ff == 32'sd0);
         end
         rpn_pkg::S_DIV: begin
            item_done = (div_cnt_ff == DCW'(rpn_pkg::DIV_STEPS - 1));
         end
         default: begin
            item_done = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rpn_pkg::S_IDLE: begin
            if (req_take) begin
               state_in = rpn_pkg::S_EXEC;
            end
         end
         rpn_pkg::S_EXEC: begin
            if (!item_done) begin
               state_in = rpn_pkg::S_OPER;
            end else begin
               state_in = last_ff ? rpn_pkg::S_OUT : rpn_pkg::S_IDLE;
            end
         end
         rpn_pkg::S_OPER: begin
            if (!item_done) begin
               state_in = rpn_pkg::S_DIV;
            end else begin
               state_in = last_ff ? rpn_pkg::S_OUT : rpn_pkg::S_IDLE;
            end
         end
         rpn_pkg::S_DIV: begin
            if (item_done) begin
               state_in = last_ff ? rpn_pkg::S_OUT : rpn_pkg::S_IDLE;
            end
         end
         rpn_pkg::S_OUT: begin
            if (out_load) begin
               state_in = rpn_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rpn_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      top_in        = top_ff;
      cleared_in    = cleared_ff;
      err_in        = err_ff;
      sym_in        = sym_ff;
      last_in       = last_ff;
      div_rem_in    = div_rem_ff;
      div_quot_in   = div_quot_ff;
      div_den_in    = div_den_ff;
      div_neg_in    = div_neg_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = cnt_m1[AW-1:0];
      mem_raddr     = cnt_m2;
      case (state_ff)
         rpn_pkg::S_IDLE: begin
            if (req_take) begin
               sym_in  = req_symbol;
               last_in = req_last;
            end
         end
         rpn_pkg::S_EXEC: begin
            if (active) begin
               if (sym_ff == rpn_pkg::CH_ENTER) begin
                  if (count_ff == CW'(STACK_DEPTH)) begin
                     err_in = rpn_pkg::STATUS_FULL;
                  end else begin
                     mem_we   = (count_ff != CW'(0));
                     top_in   = 32'sd0;
                     count_in = count_ff + CW'(1);
                  end
               end else if (is_digit) begin
                  if (count_ff == CW'(0)) begin
                     err_in = rpn_pkg::STATUS_EMPTY;
                  end else if (digit_ovf) begin
                     err_in = rpn_pkg::STATUS_RANGE;
                  end else begin
                     top_in = digit_val[31:0];
                  end
               end else if (sym_ff == rpn_pkg::CH_CLEAR) begin
                  count_in   = CW'(0);
                  cleared_in = 1'b1;
               end else if (count_ff < CW'(2)) begin
                  err_in = rpn_pkg::STATUS_EMPTY;
               end else begin
                  mem_re = 1'b1;
               end
            end
         end
         rpn_pkg::S_OPER: begin
            if (sym_ff == rpn_pkg::CH_DIVIDE) begin
               if (top_ff == 32'sd0) begin
                  err_in = rpn_pkg::STATUS_DIV_ZERO;
               end else begin
                  div_rem_in  = 32'd0;
                  div_quot_in = b_mag;
                  div_den_in  = a_mag;
                  div_neg_in  = rd_ff[31] ^ top_ff[31];
                  div_cnt_in  = DCW'(0);
               end
            end else begin
               count_in = cnt_m1;
               case (sym_ff)
                  rpn_pkg::CH_PLUS:  top_in = $signed(rd_ff) + top_ff;
                  rpn_pkg::CH_MINUS: top_in = $signed(rd_ff) - top_ff;
                  rpn_pkg::CH_TIMES: top_in = $signed(rd_ff) * top_ff;
                  default:           top_in = 32'sd0;
               endcase
            end
         end
         rpn_pkg::S_DIV: begin
            div_rem_in  = div_bit ? 32'(div_shift - {1'b0, div_den_ff}) : div_shift[31:0];
            div_quot_in = div_q_next;
            div_cnt_in  = div_cnt_ff + DCW'(1);
            if (item_done) begin
               top_in   = div_result;
               count_in = cnt_m1;
            end
         end
         rpn_pkg::S_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = 32'sd0;
               if (cleared_ff) begin
                  rsp_status_in = rpn_pkg::STATUS_CLEARED;
               end else if (err_ff != rpn_pkg::STATUS_OK) begin
                  rsp_status_in = err_ff;
               end else if (count_ff == CW'(0)) begin
                  rsp_status_in = rpn_pkg::STATUS_EMPTY;
               end else begin
                  rsp_status_in = rpn_pkg::STATUS_OK;
                  rsp_value_in  = top_ff;
               end
               count_in   = CW'(0);
               cleared_in = 1'b0;
               err_in     = rpn_pkg::STATUS_OK;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= top_ff;
      end
      if (mem_re) begin
         rd_ff <= stack_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpn_pkg::S_IDLE;
         count_ff     <= '0;
         cleared_ff   <= 1'b0;
         err_ff       <= rpn_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cleared_ff   <= cleared_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      sym_ff        <= sym_in;
      last_ff       <= last_in;
      div_rem_ff    <= div_rem_in;
      div_quot_ff   <= div_quot_in;
      div_den_ff    <= div_den_in;
      div_neg_ff    <= div_neg_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   `RPN_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(STACK_DEPTH), "stack count overflow")
   `RPN_ASSERT_SAME(a_err_value_zero, rsp_valid_ff && (rsp_status_ff != rpn_pkg::STATUS_OK),
      rsp_value_ff == 32'sd0, "nonzero value with error status")
   `RPN_ASSERT_NEXT(a_out_resets, (state_ff == rpn_pkg::S_OUT) && out_load,
      (count_ff == CW'(0)) && !cleared_ff && (err_ff == rpn_pkg::STATUS_OK),
      "stack not reset after response")
   `RPN_ASSERT_NEXT(a_div_start, (state_ff == rpn_pkg::S_OPER) &&
      (sym_ff == rpn_pkg::CH_DIVIDE) && (top_ff != 32'sd0),
      (state_ff == rpn_pkg::S_DIV) && (div_cnt_ff == DCW'(0)), "divider did not start")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

class calc_scoreboard;
   typedef struct packed {
      logic signed [31:0] value;
      logic [2:0]         status;
   } answer_type;

   localparam int DEPTH = 32;

   logic signed [31:0] entries [DEPTH];
   int unsigned        depth;
   bit                 cleared;
   logic [2:0]         fault;
   answer_type         answers [$];
   int                 errors;
   int                 checked;
   int                 seen [8];

   function new();
      restart();
      errors  = 0;
      checked = 0;
      foreach (seen[i]) seen[i] = 0;
   endfunction

   function void restart();
      foreach (entries[i]) entries[i] = 0;
      depth   = 0;
      cleared = 0;
      fault   = rpn_pkg::STATUS_OK;
   endfunction

   function void flag(logic [2:0] code);
      if (fault == rpn_pkg::STATUS_OK) fault = code;
   endfunction

   function void evaluate(logic [7:0] sym);
      logic signed [31:0] lhs;
      logic signed [31:0] rhs;
      logic signed [31:0] res;
      longint             grown;
      int                 digit;
      bit                 keep;
      if (cleared || fault != rpn_pkg::STATUS_OK) return;
      if (sym == rpn_pkg::CH_ENTER) begin
         if (depth >= DEPTH) begin
            flag(rpn_pkg::STATUS_FULL);
         end else begin
            entries[depth] = 0;
            depth++;
         end
      end else if (sym >= rpn_pkg::CH_ZERO && sym <= rpn_pkg::CH_NINE) begin
         if (depth == 0) begin
            flag(rpn_pkg::STATUS_EMPTY);
         end else begin
            digit = sym - rpn_pkg::CH_ZERO;
            grown = entries[depth - 1];
            if (grown < 0) grown = grown * 10 - digit;
            else grown = grown * 10 + digit;
            if (grown > 64'sd2147483647 || grown < -64'sd2147483648) begin
               flag(rpn_pkg::STATUS_RANGE);
            end else begin
               entries[depth - 1] = grown[31:0];
            end
         end
      end else if (sym == rpn_pkg::CH_CLEAR) begin
         depth   = 0;
         cleared = 1;
      end else if (depth < 2) begin
         flag(rpn_pkg::STATUS_EMPTY);
      end else begin
         rhs  = entries[depth - 1];
         lhs  = entries[depth - 2];
         keep = 1;
         res  = 0;
         case (sym)
            rpn_pkg::CH_PLUS: begin
               res = lhs + rhs;
            end
            rpn_pkg::CH_MINUS: begin
               res = lhs - rhs;
            end
            rpn_pkg::CH_TIMES: begin
               res = lhs * rhs;
            end
            rpn_pkg::CH_DIVIDE: begin
               if (rhs == 0) begin
                  flag(rpn_pkg::STATUS_DIV_ZERO);
                  keep = 0;
               end else if (lhs == 32'sh80000000 && rhs == -32'sd1) begin
                  res = lhs;
               end else begin
                  res = lhs / rhs;
               end
            end
            default: begin
               res = 0;
            end
         endcase
         if (keep) begin
            depth--;
            entries[depth - 1] = res;
         end
      end
   endfunction

   function void note_input(logic [7:0] sym, logic last);
      answer_type ans;
      evaluate(sym);
      if (last) begin
         ans.value = 0;
         if (cleared) begin
            ans.status = rpn_pkg::STATUS_CLEARED;
         end else if (fault != rpn_pkg::STATUS_OK) begin
            ans.status = fault;
         end else if (depth == 0) begin
            ans.status = rpn_pkg::STATUS_EMPTY;
         end else begin
            ans.status = rpn_pkg::STATUS_OK;
            ans.value  = entries[depth - 1];
         end
         answers.push_back(ans);
         restart();
      end
   endfunction

   function void check_result(logic signed [31:0] value, logic [2:0] status);
      answer_type ans;
      checked++;
      seen[status]++;
      if (answers.size() == 0) begin
         errors++;
         $display("%0t: unexpected result, expected none, actual value %0d status %0d",
                  $time, value, status);
         return;
      end
      ans = answers.pop_front();
      if (value !== ans.value) begin
         errors++;
         $display("%0t: value mismatch, expected %0d, actual %0d", $time, ans.value, value);
      end
      if (status !== ans.status) begin
         errors++;
         $display("%0t: status mismatch, expected %0d, actual %0d", $time, ans.status, status);
      end
   endfunction

   function int pending();
      return answers.size();
   endfunction
endclass

module tb_top;
   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_valid  = 1'b0;
   logic               req_stall;
   logic [7:0]         req_symbol = 8'h00;
   logic               req_last   = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall  = 1'b0;
   logic signed [31:0] rsp_value;
   logic [2:0]         rsp_status;

   calc_scoreboard sb = new();

   logic [7:0] expr [$];
   int         sent      = 0;
   int         exprs     = 0;
   int         long_hold = 0;
   bit         tx_burst  = 0;
   bit         rx_burst  = 0;

   always #2 clock = ~clock;

   rpn_character_calculator_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_symbol (req_symbol),
      .req_last   (req_last),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   task automatic send_char(input logic [7:0] sym, input logic last);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_symbol <= sym;
      req_last   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(sym, last);
      sent++;
   endtask

   task automatic send_expression();
      int i;
      for (i = 0; i < expr.size(); i++) send_char(expr[i], i == expr.size() - 1);
   endtask

   function automatic void add_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) expr.push_back(s[i]);
   endfunction

   function automatic void add_digits(int n);
      repeat (n) expr.push_back(rpn_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void add_number();
      expr.push_back(rpn_pkg::CH_ENTER);
      if ($urandom_range(0, 4) == 0) add_digits($urandom_range(0, 10));
      else add_digits($urandom_range(0, 3));
   endfunction

   function automatic logic [7:0] odd_char();
      logic [7:0] ch;
      do begin
         ch = 8'($urandom_range(0, 255));
      end while (ch == rpn_pkg::CH_ENTER || ch == rpn_pkg::CH_CLEAR ||
                 (ch >= rpn_pkg::CH_ZERO && ch <= rpn_pkg::CH_NINE));
      return ch;
   endfunction

   function automatic void add_operator();
      case ($urandom_range(0, 8))
         0, 1:    expr.push_back(rpn_pkg::CH_PLUS);
         2, 3:    expr.push_back(rpn_pkg::CH_MINUS);
         4, 5:    expr.push_back(rpn_pkg::CH_TIMES);
         6, 7:    expr.push_back(rpn_pkg::CH_DIVIDE);
         default: expr.push_back(odd_char());
      endcase
   endfunction

   function automatic void build_wellformed();
      int level;
      int steps;
      int k;
      level = 0;
      steps = $urandom_range(1, 10);
      for (k = 0; k < steps; k++) begin
         if (level < 2 || $urandom_range(0, 2) == 0) begin
            add_number();
            level++;
         end else begin
            add_operator();
            level--;
            if ($urandom_range(0, 5) == 0) add_digits($urandom_range(1, 3));
         end
      end
      if ($urandom_range(0, 19) == 0) begin
         expr.insert($urandom_range(0, expr.size()), rpn_pkg::CH_CLEAR);
      end
   endfunction

   function automatic void build_special();
      case ($urandom_range(0, 6))
         0: begin
            repeat ($urandom_range(31, 33)) expr.push_back(rpn_pkg::CH_ENTER);
            expr.push_back(rpn_pkg::CH_PLUS);
         end
         1: add_text("E0E2147483647-E1-E0E1-/");
         2: begin
            add_text("E2147483647");
            if ($urandom_range(0, 1) == 0) add_digits(1);
         end
         3: begin
            add_text("E0E214748364-");
            expr.push_back(rpn_pkg::CH_ZERO + 8'($urandom_range(7, 9)));
         end
         4: add_text($urandom_range(0, 1) ? "E99999E99999*" : "E65536E65536*");
         5: begin
            add_text("E5C");
            add_number();
            add_text("/");
         end
         default: add_text("E1E0/CE3");
      endcase
   endfunction

   initial begin : rsp_side
      int hold;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold > 0) begin
            hold      = long_hold;
            long_hold = 0;
         end else begin
            hold = rx_burst ? 0 : $urandom_range(0, 9);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_result(rsp_value, rsp_status);
         if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < 4000) begin
         @(posedge clock);
         if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))) idle = 0;
         else idle++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int pick;
      int n;
      int pos;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      expr = {}; add_text("/"); send_expression();
      expr = {}; add_text("5"); send_expression();
      expr = {}; add_text("E"); send_expression();
      expr = {}; add_text("CE"); send_expression();
      expr = {}; add_text("E1E0/"); send_expression();
      expr = {}; expr.push_back(8'h00); send_expression();
      expr = {}; add_text("E7E2"); expr.push_back(8'hFF); send_expression();
      expr = {}; add_text("E8E3-E2*E5+"); send_expression();

      while (sent < 1000) begin
         exprs++;
         if (exprs == 5 || exprs == 40) long_hold = 400;
         tx_burst = ($urandom_range(0, 3) == 0);
         expr = {};
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            build_wellformed();
            send_expression();
         end else if (pick < 80) begin
            build_wellformed();
            pos = $urandom_range(0, expr.size() - 1);
            expr[pos] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 0 && expr.size() > 1) expr.delete(0);
            send_expression();
         end else if (pick < 90) begin
            n = $urandom_range(1, 6);
            repeat (n - 1) send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            send_char(8'($urandom_range(0, 255)), 1'b1);
         end else begin
            build_special();
            send_expression();
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Sent %0d characters in %0d random expressions plus directed ones, %0d results.",
               sent, exprs, sb.checked);
      $display("Status seen: ok %0d, cleared %0d, empty %0d, full %0d, div0 %0d, range %0d.",
               sb.seen[rpn_pkg::STATUS_OK], sb.seen[rpn_pkg::STATUS_CLEARED],
               sb.seen[rpn_pkg::STATUS_EMPTY], sb.seen[rpn_pkg::STATUS_FULL],
               sb.seen[rpn_pkg::STATUS_DIV_ZERO], sb.seen[rpn_pkg::STATUS_RANGE]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

FILE: sim.f
+incdir+sv
sv/rpn_pkg.sv
sv/rpn_character_calculator_top.sv
tb/tb_top.sv
